@@ sv/iwf_pkg.sv @@
package iwf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_PASSES  = 100;
    localparam int CNT_W       = $clog2(MAX_PASSES + 1);
    localparam int PC_W        = 4;
    localparam int X_W         = 42;

    localparam logic [15:0] GAIN_KNOB_RST = 16'd819;
    localparam logic [15:0] FOLD_KNOB_RST = 16'd0;

    localparam logic CFG_GAIN_KNOB = 1'b0;
    localparam logic CFG_FOLD_KNOB = 1'b1;

    // voltages q.11, gains q.12
    localparam logic signed [16:0]    CV_LO    = -17'sd4;
    localparam logic signed [X_W-1:0] X_RAIL   = 42'sd10240;
    localparam logic signed [43:0]    X_RAIL_W = 44'sd10240;
    localparam logic signed [43:0]    X_SAT_W  = 44'sd1099511627776;
    localparam logic [22:0]           OD_RAIL  = 23'd10240;
    localparam logic [24:0]           OD_D_CAP = 25'd261326;
    localparam logic [20:0]           OD_N_CAP = 21'd1306630;
    // reciprocal of 11, scaled by 2^25
    localparam logic [21:0]           RECIP11  = 22'd3050403;
    // reciprocal of 5, scaled by 2^27
    localparam logic [24:0]           RECIP5   = 25'd26843546;
    // floor(2^22 / 5)
    localparam logic [19:0]           K_DIV5   = 20'd838860;
    localparam logic [43:0]           A1_MAX   = 44'd10995116277759;
    localparam logic [56:0]           FOLD_RND = 57'd10240;
    localparam logic [35:0]           SCL_RND  = 36'd2048;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_MULG,
        OP_SCALE,
        OP_ODN,
        OP_ODM,
        OP_CHKN,
        OP_CHKP,
        OP_M0,
        OP_M1,
        OP_RND,
        OP_D1,
        OP_D2,
        OP_UPD,
        OP_CHKIN,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_WAIT_IN,
        J_WAIT_OUT,
        J_LOW,
        J_NOT_HIGH,
        J_SIDE_NEG,
        J_AGAIN
    } jump_t;

    typedef struct packed {
        op_t             op;
        jump_t           jump;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic out_free;
        logic x_low;
        logic x_high;
        logic side_neg;
        logic again;
    } stat_t;

    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_MULG  = 4'd1;
    localparam logic [PC_W-1:0] PC_SCALE = 4'd2;
    localparam logic [PC_W-1:0] PC_ODN   = 4'd3;
    localparam logic [PC_W-1:0] PC_ODM   = 4'd4;
    localparam logic [PC_W-1:0] PC_CHKN  = 4'd5;
    localparam logic [PC_W-1:0] PC_CHKP  = 4'd6;
    localparam logic [PC_W-1:0] PC_M0    = 4'd7;
    localparam logic [PC_W-1:0] PC_M1    = 4'd8;
    localparam logic [PC_W-1:0] PC_RND   = 4'd9;
    localparam logic [PC_W-1:0] PC_D1    = 4'd10;
    localparam logic [PC_W-1:0] PC_D2    = 4'd11;
    localparam logic [PC_W-1:0] PC_UPD   = 4'd12;
    localparam logic [PC_W-1:0] PC_CHKIN = 4'd13;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd14;

    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t cw;
        cw = '{op: OP_IDLE, jump: J_NEXT, target: PC_IDLE};
        unique case (pc)
            PC_IDLE:  cw = '{op: OP_IDLE,  jump: J_WAIT_IN,  target: PC_IDLE};
            PC_MULG:  cw = '{op: OP_MULG,  jump: J_NEXT,     target: PC_IDLE};
            PC_SCALE: cw = '{op: OP_SCALE, jump: J_NEXT,     target: PC_IDLE};
            PC_ODN:   cw = '{op: OP_ODN,   jump: J_NEXT,     target: PC_IDLE};
            PC_ODM:   cw = '{op: OP_ODM,   jump: J_NEXT,     target: PC_IDLE};
            PC_CHKN:  cw = '{op: OP_CHKN,  jump: J_LOW,      target: PC_M0};
            PC_CHKP:  cw = '{op: OP_CHKP,  jump: J_NOT_HIGH, target: PC_CHKIN};
            PC_M0:    cw = '{op: OP_M0,    jump: J_NEXT,     target: PC_IDLE};
            PC_M1:    cw = '{op: OP_M1,    jump: J_NEXT,     target: PC_IDLE};
            PC_RND:   cw = '{op: OP_RND,   jump: J_NEXT,     target: PC_IDLE};
            PC_D1:    cw = '{op: OP_D1,    jump: J_NEXT,     target: PC_IDLE};
            PC_D2:    cw = '{op: OP_D2,    jump: J_NEXT,     target: PC_IDLE};
            PC_UPD:   cw = '{op: OP_UPD,   jump: J_SIDE_NEG, target: PC_CHKP};
            PC_CHKIN: cw = '{op: OP_CHKIN, jump: J_AGAIN,    target: PC_CHKN};
            PC_EMIT:  cw = '{op: OP_EMIT,  jump: J_WAIT_OUT, target: PC_IDLE};
            default:  cw = '{op: OP_IDLE,  jump: J_NEXT,     target: PC_IDLE};
        endcase
        return cw;
    endfunction

endpackage

@@ sv/iwf_seq.sv @@
module iwf_seq
(
    input  logic            clk,
    input  logic            rst_n,
    input  iwf_pkg::stat_t  stat,
    output iwf_pkg::ctrl_t  ctrl
);

    logic [iwf_pkg::PC_W-1:0] pc_reg;
    logic [iwf_pkg::PC_W-1:0] pc_next;
    logic [iwf_pkg::PC_W-1:0] pc_inc;

    assign ctrl   = iwf_pkg::ucode(pc_reg);
    assign pc_inc = pc_reg + 1'b1;

    always_comb
    begin
        unique case (ctrl.jump)
            iwf_pkg::J_NEXT:     pc_next = pc_inc;
            iwf_pkg::J_WAIT_IN:  pc_next = stat.in_fire ? pc_inc : pc_reg;
            iwf_pkg::J_WAIT_OUT: pc_next = stat.out_free ? ctrl.target : pc_reg;
            iwf_pkg::J_LOW:      pc_next = stat.x_low ? ctrl.target : pc_inc;
            iwf_pkg::J_NOT_HIGH: pc_next = !stat.x_high ? ctrl.target : pc_inc;
            iwf_pkg::J_SIDE_NEG: pc_next = stat.side_neg ? ctrl.target : pc_inc;
            iwf_pkg::J_AGAIN:    pc_next = stat.again ? ctrl.target : pc_inc;
            default:             pc_next = iwf_pkg::PC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= iwf_pkg::PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ sv/iterative_wavefolder.sv @@
// iterative wavefolder
// input stream: one item per audio sample with gain and fold control voltages;
// s_axis_tuser flags which control voltages override the knob registers.
// output stream: one item per input item, folded voltage and overdrive level.
// config: cfg_we writes cfg_wdata to knob register cfg_addr (0 gain, 1 fold);
// write only while the block is idle.
// a microcode sequencer steps a shared datapath (one multiplier per step).
// one item is taken at a time: s_axis_tready is high only while the
// sequencer waits at its first step.
// steps from accept to result: gain multiply, scaling and overdrive, then
// passes of range check and fold until the value is in range; a pass holds
// at most two folds and at most 100 passes run. the result is loaded as
// the sequencer returns to its first step, ready for the next item.
// the result sits in an output register; a stall on m_axis_tready holds it
// and the sequencer waits at its last step until the register frees up.
// reset clears the sequencer, empties the output register and loads the
// knobs with gain 0.2 and fold 0.
module iterative_wavefolder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // sample_in, gain_cv, fold_cv
    input  logic [1:0]  s_axis_tuser,   // gain_cv_active, fold_cv_active
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // folded_out, overdrive_level
);

    iwf_pkg::ctrl_t ctrl;
    iwf_pkg::stat_t stat;

    logic [15:0] gain_knob_reg;
    logic [15:0] fold_knob_reg;

    logic signed [iwf_pkg::SAMPLE_BITS-1:0] s_reg, s_next;
    logic signed [19:0]           g5_reg, g5_next;
    logic                         fneg_reg, fneg_next;
    logic [15:0]                  fmag_reg, fmag_next;
    logic signed [35:0]           prod_reg, prod_next;
    logic signed [iwf_pkg::X_W-1:0] x_reg, x_next;
    logic [20:0]                  n_reg, n_next;
    logic [16:0]                  od_reg, od_next;
    logic [39:0]                  e_reg, e_next;
    logic                         side_neg_reg, side_neg_next;
    logic [55:0]                  acc_reg, acc_next;
    logic [43:0]                  a1_reg, a1_next;
    logic [24:0]                  t_reg, t_next;
    logic [41:0]                  hp_reg, hp_next;
    logic [41:0]                  q_reg, q_next;
    logic [iwf_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;
    logic [14:0]                  fo_reg, fo_next;
    logic [16:0]                  odo_reg, odo_next;

    logic               in_fire;
    logic               out_free;
    logic               x_low;
    logic               x_high;
    logic               x_in_range;
    logic               again;
    logic signed [16:0] g_sel;
    logic signed [16:0] f_sel;
    logic signed [19:0] g_ext;
    logic signed [16:0] f_neg;
    logic [35:0]        sc_mag;
    logic [35:0]        sc_rnd;
    logic [41:0]        sc_m;
    logic [41:0]        x_abs;
    logic [24:0]        od_d;
    logic [24:0]        od_n;
    logic [42:0]        od_p;
    logic signed [iwf_pkg::X_W-1:0] e_lo_side;
    logic signed [iwf_pkg::X_W-1:0] e_hi_side;
    logic [19:0]        e_half;
    logic [35:0]        pp;
    logic [56:0]        r_sum;
    logic [44:0]        a1_w;
    logic [21:0]        a1_hi;
    logic [21:0]        a1_lo;
    logic [49:0]        tp;
    logic signed [43:0] q_ext;
    logic signed [43:0] sq;
    logic signed [43:0] xn;

    function automatic logic signed [16:0] pick_ctl
    (
        input logic [15:0]        knob,
        input logic signed [15:0] cv,
        input logic               act
    );
        logic signed [16:0] v;
        v = {cv[15], cv};
        if (!act)
        begin
            v = {1'b0, knob};
        end
        else if (v < iwf_pkg::CV_LO)
        begin
            v = iwf_pkg::CV_LO;
        end
        return v;
    endfunction

    iwf_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign s_axis_tready = (ctrl.op == iwf_pkg::OP_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign x_low         = x_reg < -iwf_pkg::X_RAIL;
    assign x_high        = x_reg > iwf_pkg::X_RAIL;
    assign x_in_range    = !x_low && !x_high;
    assign again         = !x_in_range &&
                           (cnt_reg != iwf_pkg::CNT_W'(iwf_pkg::MAX_PASSES - 1));

    assign stat = '{in_fire: in_fire, out_free: out_free, x_low: x_low,
                    x_high: x_high, side_neg: side_neg_reg, again: again};

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {odo_reg, fo_reg};

    // control selection and scaling
    assign g_sel  = pick_ctl(gain_knob_reg, s_axis_tdata[31:16], s_axis_tuser[0]);
    assign f_sel  = pick_ctl(fold_knob_reg, s_axis_tdata[47:32], s_axis_tuser[1]);
    assign g_ext  = {{3{g_sel[16]}}, g_sel};
    assign f_neg  = -f_sel;
    assign sc_mag = prod_reg[35] ? 36'(-prod_reg) : 36'(prod_reg);
    assign sc_rnd = sc_mag + iwf_pkg::SCL_RND;
    assign sc_m   = {18'd0, sc_rnd[35:12]};

    // overdrive
    assign x_abs = x_reg[iwf_pkg::X_W-1] ? 42'(-x_reg) : 42'(x_reg);
    assign od_d  = {2'd0, x_abs[22:0]} - {2'd0, iwf_pkg::OD_RAIL};
    assign od_n  = (od_d << 2) + od_d + 25'd5;
    assign od_p  = {22'd0, n_reg} * {21'd0, iwf_pkg::RECIP11};

    // fold
    assign e_lo_side = -x_reg - iwf_pkg::X_RAIL;
    assign e_hi_side = x_reg - iwf_pkg::X_RAIL;
    assign e_half    = (ctrl.op == iwf_pkg::OP_M1) ? e_reg[39:20] : e_reg[19:0];
    assign pp        = {16'd0, e_half} * {20'd0, fmag_reg};
    assign r_sum     = {1'b0, acc_reg} + iwf_pkg::FOLD_RND;
    assign a1_w      = r_sum[56:12];
    assign a1_hi     = a1_reg[43:22];
    assign a1_lo     = a1_reg[21:0];
    assign tp        = {25'd0, t_reg} * {25'd0, iwf_pkg::RECIP5};
    assign q_ext     = {2'b00, q_reg};
    assign sq        = fneg_reg ? -q_ext : q_ext;
    assign xn        = side_neg_reg ? (sq - iwf_pkg::X_RAIL_W) : (iwf_pkg::X_RAIL_W - sq);

    always_comb
    begin
        s_next        = s_reg;
        g5_next       = g5_reg;
        fneg_next     = fneg_reg;
        fmag_next     = fmag_reg;
        prod_next     = prod_reg;
        x_next        = x_reg;
        n_next        = n_reg;
        od_next       = od_reg;
        e_next        = e_reg;
        side_neg_next = side_neg_reg;
        acc_next      = acc_reg;
        a1_next       = a1_reg;
        t_next        = t_reg;
        hp_next       = hp_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        fo_next       = fo_reg;
        odo_next      = odo_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        unique case (ctrl.op)
            iwf_pkg::OP_IDLE:
            begin
                if (in_fire)
                begin
                    s_next    = s_axis_tdata[15:0];
                    g5_next   = (g_ext <<< 2) + g_ext;
                    fneg_next = f_sel[16];
                    fmag_next = f_sel[16] ? f_neg[15:0] : f_sel[15:0];
                    cnt_next  = '0;
                end
            end
            iwf_pkg::OP_MULG:
            begin
                prod_next = 36'(s_reg) * 36'(g5_reg);
            end
            iwf_pkg::OP_SCALE:
            begin
                x_next = prod_reg[35] ? $signed(-sc_m) : $signed(sc_m);
            end
            iwf_pkg::OP_ODN:
            begin
                if (x_abs[22:0] <= iwf_pkg::OD_RAIL)
                begin
                    n_next = '0;
                end
                else if (od_d >= iwf_pkg::OD_D_CAP)
                begin
                    n_next = iwf_pkg::OD_N_CAP;
                end
                else
                begin
                    n_next = od_n[20:0];
                end
            end
            iwf_pkg::OP_ODM:
            begin
                od_next = od_p[41:25];
            end
            iwf_pkg::OP_CHKN:
            begin
                e_next        = e_lo_side[39:0];
                side_neg_next = 1'b1;
            end
            iwf_pkg::OP_CHKP:
            begin
                e_next        = e_hi_side[39:0];
                side_neg_next = 1'b0;
            end
            iwf_pkg::OP_M0:
            begin
                acc_next = {20'd0, pp};
            end
            iwf_pkg::OP_M1:
            begin
                acc_next = acc_reg + {pp, 20'd0};
            end
            iwf_pkg::OP_RND:
            begin
                a1_next = (a1_w > {1'b0, iwf_pkg::A1_MAX}) ? iwf_pkg::A1_MAX : a1_w[43:0];
            end
            iwf_pkg::OP_D1:
            begin
                // a1 = hi * 2^22 + lo, and 2^22 = 5 * K_DIV5 + 4
                t_next  = {1'b0, a1_hi, 2'b00} + {3'd0, a1_lo};
                hp_next = {20'd0, a1_hi} * {22'd0, iwf_pkg::K_DIV5};
            end
            iwf_pkg::OP_D2:
            begin
                q_next = hp_reg + {19'd0, tp[49:27]};
            end
            iwf_pkg::OP_UPD:
            begin
                if (xn > iwf_pkg::X_SAT_W)
                begin
                    x_next = iwf_pkg::X_SAT_W[iwf_pkg::X_W-1:0];
                end
                else if (xn < -iwf_pkg::X_SAT_W)
                begin
                    x_next = 42'(-iwf_pkg::X_SAT_W);
                end
                else
                begin
                    x_next = xn[iwf_pkg::X_W-1:0];
                end
            end
            iwf_pkg::OP_CHKIN:
            begin
                if (again)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            iwf_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    fo_next        = x_in_range ? x_reg[14:0] : 15'd0;
                    odo_next       = od_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_axis_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_knob_reg <= iwf_pkg::GAIN_KNOB_RST;
            fold_knob_reg <= iwf_pkg::FOLD_KNOB_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    iwf_pkg::CFG_GAIN_KNOB: gain_knob_reg <= cfg_wdata;
                    iwf_pkg::CFG_FOLD_KNOB: fold_knob_reg <= cfg_wdata;
                    default:                gain_knob_reg <= gain_knob_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        g5_reg       <= g5_next;
        fneg_reg     <= fneg_next;
        fmag_reg     <= fmag_next;
        prod_reg     <= prod_next;
        x_reg        <= x_next;
        n_reg        <= n_next;
        od_reg       <= od_next;
        e_reg        <= e_next;
        side_neg_reg <= side_neg_next;
        acc_reg      <= acc_next;
        a1_reg       <= a1_next;
        t_reg        <= t_next;
        hp_reg       <= hp_next;
        q_reg        <= q_next;
        cnt_reg      <= cnt_next;
        fo_reg       <= fo_next;
        odo_reg      <= odo_next;
    end

endmodule
